// File: sv/ppa_pkg.sv
package ppa_pkg;

    localparam int MAX_ASSETS   = 4;
    localparam int RET_W        = 32;
    localparam int WEIGHT_W     = 32;
    localparam int ROOF_W       = 32;
    localparam int DISC_W       = 31;
    localparam int PRICE_W      = 32;
    localparam int ACC_W        = 48;
    localparam int TERM_W       = 46;
    localparam int CFG_IDX_W    = 3;
    localparam int EXP_TERMS    = 8;
    localparam int CNT_W        = 4;
    localparam int RECIP_SHIFT  = 33;
    localparam int RECIP_W      = 34;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] Q30_ONE   = 32'd1073741824;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROOF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT0  = 3'd2;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_FRAC,
        LN_HMUL,
        LN_HDIV,
        LN_HADD,
        LN_SCALE,
        LN_WMUL,
        LN_DONE
    } lane_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_PAY,
        T_OUT
    } top_state_t;

    typedef struct packed {
        logic                      done;
        logic signed [TERM_W-1:0]  term;
    } lane_stat_t;

    // ceil(2^33 / n): floor(q / n) == (q * recip) >> 33 for any 30-bit q
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd1:    r = 34'd8589934592;
            4'd2:    r = 34'd4294967296;
            4'd3:    r = 34'd2863311531;
            4'd4:    r = 34'd2147483648;
            4'd5:    r = 34'd1717986919;
            4'd6:    r = 34'd1431655766;
            4'd7:    r = 34'd1227133514;
            4'd8:    r = 34'd1073741824;
            default: r = 34'd8589934592;
        endcase
        return r;
    endfunction

endpackage

// File: sv/ppa_lane.sv
// One asset: weight * (exp(ret) - 1), Horner series stepped by a state sequencer.
module ppa_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ppa_pkg::RET_W-1:0]    ret,
    input  logic signed [ppa_pkg::WEIGHT_W-1:0] weight,
    output ppa_pkg::lane_stat_t                 stat
);
    import ppa_pkg::*;

    lane_state_t state_reg, state_next;

    logic signed [63:0]        t_reg;
    logic [29:0]               z_reg;
    logic [4:0]                kb_reg;
    logic [31:0]               p_reg;
    logic [CNT_W-1:0]          n_reg;
    logic [59:0]               prod_reg;
    logic [63:0]               qm_reg;
    logic signed [33:0]        m_reg;
    logic signed [65:0]        wprod_reg;

    logic ld_t, ld_z, ld_prod, ld_qm, ld_p, ld_m, ld_w, done;

    logic [63:0]  ub;
    logic [59:0]  frac_prod;
    logic [63:0]  shifted;
    logic [33:0]  ee;
    logic [61:0]  pz;

    assign ub        = t_reg + 64'h4000_0000_0000_0000;
    assign frac_prod = t_reg[57:28] * LN2_Q30;
    assign pz        = p_reg * {2'b00, z_reg};
    assign shifted   = {32'd0, p_reg} << kb_reg;
    assign ee        = {2'b00, shifted[57:26]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE:  if (start) state_next = LN_FRAC;
            LN_FRAC:  state_next = LN_HMUL;
            LN_HMUL:  state_next = LN_HDIV;
            LN_HDIV:  state_next = LN_HADD;
            LN_HADD:  state_next = (n_reg == CNT_W'(1)) ? LN_SCALE : LN_HMUL;
            LN_SCALE: state_next = LN_WMUL;
            LN_WMUL:  state_next = LN_DONE;
            LN_DONE:  state_next = LN_IDLE;
            default:  state_next = LN_IDLE;
        endcase
    end

    always_comb
    begin
        ld_t = 1'b0; ld_z = 1'b0; ld_prod = 1'b0; ld_qm = 1'b0;
        ld_p = 1'b0; ld_m = 1'b0; ld_w = 1'b0; done = 1'b0;
        unique case (state_reg)
            LN_IDLE:  ld_t = start;
            LN_FRAC:  ld_z = 1'b1;
            LN_HMUL:  ld_prod = 1'b1;
            LN_HDIV:  ld_qm = 1'b1;
            LN_HADD:  ld_p = 1'b1;
            LN_SCALE: ld_m = 1'b1;
            LN_WMUL:  ld_w = 1'b1;
            LN_DONE:  done = 1'b1;
            default:  done = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LN_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld_t)
            t_reg <= 64'(ret * $signed({1'b0, LOG2E_Q30}));
        if (ld_z)
        begin
            z_reg  <= frac_prod[59:30];
            kb_reg <= ub[62:58];
            p_reg  <= Q30_ONE;
            n_reg  <= CNT_W'(EXP_TERMS);
        end
        if (ld_prod)
            prod_reg <= pz[59:0];
        if (ld_qm)
            qm_reg <= prod_reg[59:30] * recip(n_reg);
        if (ld_p)
        begin
            p_reg <= Q30_ONE + {1'b0, qm_reg[63:RECIP_SHIFT]};
            n_reg <= n_reg - CNT_W'(1);
        end
        if (ld_m)
            m_reg <= $signed(ee) - 34'sd1048576;
        if (ld_w)
            wprod_reg <= 66'(weight * m_reg);
    end

    assign stat.done = done;
    assign stat.term = wprod_reg[65:20];

endmodule

// File: sv/ppa_merge.sv
// Add the lane terms into the running gain and saturate to the accumulator range.
module ppa_merge #(
    parameter int NUM_ASSETS = ppa_pkg::MAX_ASSETS
) (
    input  logic signed [ppa_pkg::ACC_W-1:0]  gain,
    input  ppa_pkg::lane_stat_t               stat [NUM_ASSETS],
    output logic signed [ppa_pkg::ACC_W-1:0]  gain_sat
);
    import ppa_pkg::*;

    localparam int SUM_W = ACC_W + 4;
    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_W-1)) - 1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -SUM_W'(64'sd1 <<< (ACC_W-1));

    logic signed [SUM_W-1:0] sum;

    always_comb
    begin
        sum = SUM_W'(gain);
        for (int i = 0; i < NUM_ASSETS; i++)
            sum = sum + SUM_W'(stat[i].term);
        priority if (sum > ACC_MAX)
            gain_sat = ACC_MAX[ACC_W-1:0];
        else if (sum < ACC_MIN)
            gain_sat = ACC_MIN[ACC_W-1:0];
        else
            gain_sat = sum[ACC_W-1:0];
    end

endmodule

// File: sv/pagoda_payoff_accumulator.sv
// Pagoda option path payoff. Each input word is one time step with the Q4.28
// log-returns of up to four assets (ret_0 in the lowest bits of s_tdata);
// s_tlast marks the final step of a path. Every asset has its own lane that
// forms weight * (exp(ret) - 1) with an 8-term Horner series; the lanes run in
// parallel and a merge stage adds their terms into a 48-bit saturating gain.
// On the last step the gain is clamped to [0, roof_limit], scaled by the
// Q1.30 discount factor and sent out as one Q16.16 price word; the gain then
// clears. Timing: a new step is accepted only once the previous one is through
// the lanes: after acceptance they step through the fraction, a multiply, divide
// and add per Horner term for eight terms, the shift and the weight multiply,
// then the merge loads the gain and ready goes high. A last step adds the discount
// multiply and output load, and waits while the output register still holds
// an unaccepted price. The output register holds a finished price while new
// steps are accepted. Configuration: cfg_index 0 roof_limit, 1 discount_factor,
// 2..5 weights of assets 0..3; write only while idle.
module pagoda_payoff_accumulator #(
    parameter int NUM_ASSETS = ppa_pkg::MAX_ASSETS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // ret_0 [31:0], ret_1 [63:32], ret_2 [95:64], ret_3 [127:96]
    input  logic [ppa_pkg::MAX_ASSETS*ppa_pkg::RET_W-1:0] s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // price [31:0]
    output logic [ppa_pkg::PRICE_W-1:0]          m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [ppa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppa_pkg::ROOF_W-1:0]           cfg_wr_data
);
    import ppa_pkg::*;

    top_state_t state_reg, state_next;

    logic [ROOF_W-1:0]                 roof_reg;
    logic [DISC_W-1:0]                 disc_reg;
    logic signed [WEIGHT_W-1:0]        weight_reg [NUM_ASSETS];
    logic signed [ACC_W-1:0]           gain_reg;
    logic                              last_reg;
    logic [62:0]                       pay_reg;
    logic [PRICE_W-1:0]                out_reg;
    logic                              out_valid_reg;

    lane_stat_t                        stat [NUM_ASSETS];
    logic signed [ACC_W-1:0]           gain_sat;
    logic                              accept, lanes_done, out_free;
    logic                              ld_gain, ld_pay, ld_out;
    logic [ROOF_W-1:0]                 clamp;
    logic [CFG_IDX_W-1:0]              widx;

    assign accept   = s_tvalid & s_tready;
    assign out_free = ~out_valid_reg | m_tready;

    always_comb
    begin
        lanes_done = 1'b1;
        for (int i = 0; i < NUM_ASSETS; i++)
            lanes_done = lanes_done & stat[i].done;
    end

    // one lane per asset, all started by the accepted word
    for (genvar g = 0; g < NUM_ASSETS; g++)
    begin : g_lane
        ppa_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (accept),
            .ret    (s_tdata[g*RET_W +: RET_W]),
            .weight (weight_reg[g]),
            .stat   (stat[g])
        );
    end

    ppa_merge #(
        .NUM_ASSETS (NUM_ASSETS)
    ) u_merge (
        .gain     (gain_reg),
        .stat     (stat),
        .gain_sat (gain_sat)
    );

    // clamp the gain to [0, roof]
    always_comb
    begin
        priority if (gain_reg <= 0)
            clamp = '0;
        else if (gain_reg > $signed({16'd0, roof_reg}))
            clamp = roof_reg;
        else
            clamp = gain_reg[ROOF_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (accept) state_next = T_RUN;
            T_RUN:  if (lanes_done) state_next = last_reg ? T_PAY : T_IDLE;
            T_PAY:  state_next = T_OUT;
            T_OUT:  if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        ld_gain  = 1'b0;
        ld_pay   = 1'b0;
        ld_out   = 1'b0;
        unique case (state_reg)
            T_IDLE: s_tready = 1'b1;
            T_RUN:  ld_gain = lanes_done;
            T_PAY:  ld_pay = 1'b1;
            T_OUT:  ld_out = out_free;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            gain_reg      <= '0;
            roof_reg      <= '0;
            disc_reg      <= Q30_ONE[DISC_W-1:0];
            for (int i = 0; i < NUM_ASSETS; i++)
                weight_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ld_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            // drop the gain once the path is paid
            if (ld_gain)
                gain_reg <= gain_sat;
            else if (ld_pay)
                gain_reg <= '0;
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_ROOF)
                    roof_reg <= cfg_wr_data;
                else if (cfg_index == CFG_DISCOUNT)
                    disc_reg <= cfg_wr_data[DISC_W-1:0];
                for (int i = 0; i < NUM_ASSETS; i++)
                    if (widx == CFG_IDX_W'(i) && cfg_index >= CFG_WEIGHT0)
                        weight_reg[i] <= cfg_wr_data;
            end
        end
    end

    assign widx = cfg_index - CFG_WEIGHT0;

    always_ff @(posedge clk)
    begin
        if (accept)
            last_reg <= s_tlast;
        if (ld_pay)
            pay_reg <= clamp * disc_reg;
        if (ld_out)
            out_reg <= (pay_reg[62]) ? '1 : pay_reg[61:30];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
